/* sv/sphist_pkg.sv */
package sphist_pkg;

	// Table geometry
	localparam int SPRITE_COUNT_DEF = 16;
	localparam int MAX_RESULTS      = 16;
	localparam int CNT_W            = $clog2(MAX_RESULTS + 1);

	// Field widths
	localparam int CMD_W   = 3;
	localparam int IDX_W   = 4;
	localparam int COORD_W = 8;
	localparam int PAT_W   = 8;
	localparam int ACT_W   = 2;
	localparam int CFG_W   = 8;
	localparam int REG_IDX_W = 2;
	localparam int S_DATA_W  = 32;
	localparam int M_DATA_W  = 32;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_HIDE_ALL = 3'd0;
	localparam logic [CMD_W-1:0] CMD_SHOW     = 3'd1;
	localparam logic [CMD_W-1:0] CMD_HIDE_ONE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_ERASE    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DRAW     = 3'd4;

	// Action codes
	localparam logic [ACT_W-1:0] ACT_ERASE      = 2'd0;
	localparam logic [ACT_W-1:0] ACT_DRAW_SMALL = 2'd1;
	localparam logic [ACT_W-1:0] ACT_DRAW_LARGE = 2'd2;

	// Register indexes
	localparam logic [REG_IDX_W-1:0] REG_RANGE_X_SMALL = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_RANGE_X_LARGE = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_RANGE_Y       = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_LARGE_START   = 2'd3;

	localparam logic [COORD_W-1:0] HIDDEN_Y = 8'he0;

	typedef struct packed {
		logic [CFG_W-1:0] range_x_small;
		logic [CFG_W-1:0] range_x_large;
		logic [CFG_W-1:0] range_y;
		logic [CFG_W-1:0] large_pattern_start;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		range_x_small:       8'd255,
		range_x_large:       8'd255,
		range_y:             8'd224,
		large_pattern_start: 8'd128
	};

	// One table entry, kept as one memory row
	typedef struct packed {
		logic [PAT_W-1:0]   pattern;
		logic [COORD_W-1:0] cur_x;
		logic [COORD_W-1:0] cur_y;
		logic [COORD_W-1:0] mid_x;
		logic [COORD_W-1:0] mid_y;
		logic [COORD_W-1:0] old_x;
		logic [COORD_W-1:0] old_y;
	} row_t;

	localparam row_t ROW_RESET = '{
		pattern: '0,
		cur_x:   '0,
		cur_y:   HIDDEN_Y,
		mid_x:   '0,
		mid_y:   HIDDEN_Y,
		old_x:   '0,
		old_y:   HIDDEN_Y
	};

	typedef struct packed {
		logic [ACT_W-1:0]   action;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [PAT_W-1:0]   pattern;
	} act_t;

	typedef struct packed {
		logic emit;
		act_t act;
		row_t row;
	} unit_res_t;

endpackage

/* sv/sphist_ram.sv */
module sphist_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one row, read one row registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* sv/sphist_unit.sv */
module sphist_unit (
	input  logic [sphist_pkg::CMD_W-1:0]   cmd,
	input  sphist_pkg::cfg_t               cfg,
	input  sphist_pkg::row_t               row,
	input  logic [sphist_pkg::COORD_W-1:0] x_pos,
	input  logic [sphist_pkg::COORD_W-1:0] y_pos,
	input  logic [sphist_pkg::PAT_W-1:0]   pattern_in,
	output sphist_pkg::unit_res_t          res
);

	import sphist_pkg::*;

	logic old_vis, mid_vis, cur_vis, is_large;

	assign old_vis  = row.old_y < cfg.range_y;
	assign mid_vis  = row.mid_y < cfg.range_y;
	assign cur_vis  = row.cur_y < cfg.range_y;
	assign is_large = row.pattern >= cfg.large_pattern_start;

	// Compare and update one entry for the current command
	always_comb begin
		res.emit = 1'b0;
		res.act  = '{action: ACT_ERASE, x: row.old_x, y: row.old_y, pattern: '0};
		res.row  = row;
		unique case (cmd)
			CMD_SHOW: begin
				res.row.cur_x   = x_pos;
				res.row.cur_y   = y_pos;
				res.row.pattern = pattern_in;
			end
			CMD_HIDE_ONE: begin
				res.row.cur_y = HIDDEN_Y;
			end
			CMD_ERASE: begin
				res.emit = old_vis && (row.old_x < cfg.range_x_small);
				if (mid_vis || old_vis) begin
					res.row.old_x = row.mid_x;
					res.row.old_y = row.mid_y;
				end
			end
			CMD_DRAW: begin
				res.act.x       = row.cur_x;
				res.act.y       = row.cur_y;
				res.act.pattern = row.pattern;
				if (is_large) begin
					res.act.action = ACT_DRAW_LARGE;
					res.emit       = cur_vis && (row.cur_x < cfg.range_x_large);
				end else begin
					res.act.action = ACT_DRAW_SMALL;
					res.emit       = cur_vis && (row.cur_x < cfg.range_x_small);
				end
				if (cur_vis || mid_vis) begin
					res.row.mid_x = row.cur_x;
					res.row.mid_y = row.cur_y;
				end
			end
			default: begin
				res.row = row;
			end
		endcase
	end

endmodule

/* sv/sprite_position_history_table.sv */
// Sprite position history table.
// Input channel s_*: one item is a command (hide all, show, hide one, erase
// pass, draw pass) with entry index, position and pattern. Output channel
// m_*: erase and draw actions, tlast on the final action of a pass. A pass
// with nothing to emit sends no item; at most sixteen actions per pass.
// Configuration: cfg_we/cfg_index/cfg_data write the x and y limits and the
// large-pattern threshold; write only while the block is idle.
// Sequencing: hide all is done in the idle state; show and hide one read the
// row, then write it back. A pass visits every entry in turn, each a
// registered read of the row memory and then one trip through the shared
// compare/update unit, with a final flush while an action is held. s_tready
// is high only between items.
// Each action is held back until the next one is found or the pass ends, so
// tlast can be set: it moves to the output register when the next emitting
// entry is processed, or in the final flush for the last action of the pass.
// A stalled receiver holds the output register; the pass halts on an action
// it must emit while one is held, and resumes when the output frees up.
// Reset loads the default limits and marks every entry as never written,
// which reads as x zero and all y hidden; no clearing pass is needed.
module sprite_position_history_table #(
	parameter int SPRITE_COUNT = sphist_pkg::SPRITE_COUNT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// command[2:0], index[6:3], x_pos[14:7], y_pos[22:15], pattern_in[30:23]
	input  logic [sphist_pkg::S_DATA_W-1:0]    s_tdata,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// action[1:0], out_x[9:2], out_y[17:10], out_pattern[25:18]
	output logic [sphist_pkg::M_DATA_W-1:0]    m_tdata,
	output logic                               m_tlast,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	input  logic                               cfg_we,
	input  logic [sphist_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [sphist_pkg::CFG_W-1:0]       cfg_data
);

	import sphist_pkg::*;

	localparam int AW = (SPRITE_COUNT > 1) ? $clog2(SPRITE_COUNT) : 1;
	localparam logic [AW-1:0] LAST_PTR = AW'(SPRITE_COUNT - 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_READ  = 2'd1;
	localparam logic [1:0] ST_PROC  = 2'd2;
	localparam logic [1:0] ST_FLUSH = 2'd3;

	logic [1:0]              state_q;
	cfg_t                    cfg_q;
	logic [SPRITE_COUNT-1:0] valid_q;
	logic [SPRITE_COUNT-1:0] hide_q;
	logic [AW-1:0]           ptr_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    pend_valid_q;
	act_t                    pend_q;
	act_t                    out_q;
	logic                    out_valid_q;
	logic                    out_last_q;

	logic [CMD_W-1:0]   cmd_q;
	logic [COORD_W-1:0] x_q;
	logic [COORD_W-1:0] y_q;
	logic [PAT_W-1:0]   pat_q;

	logic [CMD_W-1:0]   in_cmd;
	logic [IDX_W-1:0]   in_idx;
	logic               in_fire;
	logic               idx_ok;
	row_t               rd_row;
	row_t               eff_row;
	unit_res_t          res;
	logic               is_pass;
	logic               take;
	logic               out_free;
	logic               stall;
	logic               wr_en;
	logic               pass_end;
	logic               out_load;

	assign in_cmd  = s_tdata[2:0];
	assign in_idx  = s_tdata[6:3];
	assign s_tready = (state_q == ST_IDLE);
	assign in_fire = s_tvalid && s_tready;
	assign idx_ok  = {3'b000, in_idx} < 7'(SPRITE_COUNT);

	// Row memory, one entry per sprite
	sphist_ram #(
		.WIDTH($bits(row_t)),
		.DEPTH(SPRITE_COUNT),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(ptr_q),
		.wdata(res.row),
		.raddr(ptr_q),
		.rdata(rd_row)
	);

	// Apply reset and hide-all marks to the row read back
	always_comb begin
		eff_row = rd_row;
		if (!valid_q[ptr_q]) begin
			eff_row = ROW_RESET;
		end else if (hide_q[ptr_q]) begin
			eff_row.cur_y = HIDDEN_Y;
			eff_row.mid_y = HIDDEN_Y;
			eff_row.old_y = HIDDEN_Y;
		end
	end

	sphist_unit u_unit (
		.cmd       (cmd_q),
		.cfg       (cfg_q),
		.row       (eff_row),
		.x_pos     (x_q),
		.y_pos     (y_q),
		.pattern_in(pat_q),
		.res       (res)
	);

	assign is_pass  = (cmd_q == CMD_ERASE) || (cmd_q == CMD_DRAW);
	assign take     = is_pass && res.emit && (cnt_q < CNT_W'(MAX_RESULTS));
	assign out_free = !out_valid_q || m_tready;
	assign stall    = take && pend_valid_q && !out_free;
	assign wr_en    = (state_q == ST_PROC) && !stall;
	assign pass_end = (cmd_q == CMD_ERASE) ? (ptr_q == LAST_PTR) : (ptr_q == '0);
	assign out_load = ((state_q == ST_PROC) && take && !stall && pend_valid_q) ||
		((state_q == ST_FLUSH) && out_free);

	// Sequence commands over the table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cfg_q        <= CFG_RESET;
			valid_q      <= '0;
			hide_q       <= '0;
			ptr_q        <= '0;
			cnt_q        <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			out_last_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_RANGE_X_SMALL: cfg_q.range_x_small       <= cfg_data;
					REG_RANGE_X_LARGE: cfg_q.range_x_large       <= cfg_data;
					REG_RANGE_Y:       cfg_q.range_y             <= cfg_data;
					REG_LARGE_START:   cfg_q.large_pattern_start <= cfg_data;
				endcase
			end
			if (out_valid_q && m_tready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						cnt_q <= '0;
						priority if (in_cmd == CMD_HIDE_ALL) begin
							hide_q <= '1;
						end else if (in_cmd == CMD_SHOW || in_cmd == CMD_HIDE_ONE) begin
							if (idx_ok) begin
								ptr_q   <= AW'(in_idx);
								state_q <= ST_READ;
							end
						end else if (in_cmd == CMD_ERASE) begin
							ptr_q   <= '0;
							state_q <= ST_READ;
						end else if (in_cmd == CMD_DRAW) begin
							ptr_q   <= LAST_PTR;
							state_q <= ST_READ;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_PROC;
				end
				ST_PROC: begin
					if (!stall) begin
						valid_q[ptr_q] <= 1'b1;
						hide_q[ptr_q]  <= 1'b0;
						if (take) begin
							cnt_q        <= cnt_q + 1'b1;
							pend_valid_q <= 1'b1;
							if (pend_valid_q) begin
								out_valid_q <= 1'b1;
								out_last_q  <= 1'b0;
							end
						end
						if (!is_pass) begin
							state_q <= ST_IDLE;
						end else if (pass_end) begin
							state_q <= (pend_valid_q || take) ? ST_FLUSH : ST_IDLE;
						end else begin
							ptr_q   <= (cmd_q == CMD_ERASE) ? ptr_q + 1'b1 : ptr_q - 1'b1;
							state_q <= ST_READ;
						end
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_last_q   <= 1'b1;
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold command fields and action payloads
	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_q <= in_cmd;
			x_q   <= s_tdata[14:7];
			y_q   <= s_tdata[22:15];
			pat_q <= s_tdata[30:23];
		end
		if (state_q == ST_PROC && take && !stall) begin
			pend_q <= res.act;
			if (pend_valid_q) begin
				out_q <= pend_q;
			end
		end
		if (state_q == ST_FLUSH && out_free) begin
			out_q <= pend_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {6'b0, out_q.pattern, out_q.y, out_q.x, out_q.action};

endmodule

/* sv/sphist_checker.sv */
module sphist_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic [sphist_pkg::S_DATA_W-1:0] s_tdata,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic [sphist_pkg::M_DATA_W-1:0] m_tdata,
	input logic                            m_tlast,
	input logic                            m_tvalid,
	input logic                            m_tready
);

	import sphist_pkg::*;

	// Stalled output item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output item changed while stalled");

	// No action appears in the cycle after a command is taken
	a_no_early_out: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("output item rose right after command");

	// A pass keeps the input closed on its next cycle
	a_pass_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tdata[2:0] == CMD_ERASE || s_tdata[2:0] == CMD_DRAW)
		|=> !s_tready)
		else $error("input open during pass");

	// Erase actions carry no pattern
	a_erase_pat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] == ACT_ERASE |-> m_tdata[25:18] == '0)
		else $error("erase item with pattern");

	// Only defined action codes
	a_action_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[1:0] != 2'd3)
		else $error("undefined action code");

endmodule

bind sprite_position_history_table sphist_checker u_sphist_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tdata (s_tdata),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready)
);

/* tb/sprite_position_history_table_tb.sv */
`timescale 1ns / 1ps

module sprite_position_history_table_tb;

	import sphist_pkg::*;

	localparam int CLK_HALF       = 4;
	localparam int SETTLE_CYCLES  = 2 * SPRITE_COUNT_DEF + 16;
	localparam int PHASES         = 10;
	localparam int ITEMS_PER_PHASE = 50;
	localparam int MAX_PRINTED    = 50;

	// Command codes the block ignores
	localparam logic [CMD_W-1:0] CMD_SPARE_5 = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

	// Input item, command in the lowest bits
	typedef struct packed {
		logic [PAT_W-1:0]   pattern;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] x;
		logic [IDX_W-1:0]   index;
		logic [CMD_W-1:0]   command;
	} sprite_cmd_t;

	typedef struct packed {
		act_t act;
		logic last;
	} sprite_action_t;

	class sprite_action_scoreboard;
		row_t           table_rows[SPRITE_COUNT_DEF];
		cfg_t           limits;
		sprite_action_t expected_actions[$];
		sprite_action_t pass_actions[$];
		int             mismatches;

		function new();
			limits = CFG_RESET;
			foreach (table_rows[i]) table_rows[i] = ROW_RESET;
			mismatches = 0;
		endfunction

		function void set_register(input logic [REG_IDX_W-1:0] idx,
			input logic [CFG_W-1:0] value);
			case (idx)
				REG_RANGE_X_SMALL: limits.range_x_small = value;
				REG_RANGE_X_LARGE: limits.range_x_large = value;
				REG_RANGE_Y:       limits.range_y = value;
				REG_LARGE_START:   limits.large_pattern_start = value;
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_actions.size();
		endfunction

		// Collect one action of the running pass, capped per pass
		function void add_action(input logic [ACT_W-1:0] kind,
			input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
			input logic [PAT_W-1:0] pattern);
			sprite_action_t a;
			if (pass_actions.size() >= MAX_RESULTS) return;
			a.act.action  = kind;
			a.act.x       = x;
			a.act.y       = y;
			a.act.pattern = pattern;
			a.last        = 1'b0;
			pass_actions.push_back(a);
		endfunction

		// Flag the final action of the pass and queue them all
		function void close_pass();
			sprite_action_t a;
			foreach (pass_actions[k]) begin
				a = pass_actions[k];
				a.last = (k == pass_actions.size() - 1);
				expected_actions.push_back(a);
			end
			pass_actions.delete();
		endfunction

		// Apply one accepted command to the table and queue its actions
		function void note_command(input sprite_cmd_t c);
			row_t r;
			case (c.command)
				CMD_HIDE_ALL: begin
					foreach (table_rows[i]) begin
						table_rows[i].cur_y = HIDDEN_Y;
						table_rows[i].mid_y = HIDDEN_Y;
						table_rows[i].old_y = HIDDEN_Y;
					end
				end
				CMD_SHOW: begin
					table_rows[c.index].cur_x   = c.x;
					table_rows[c.index].cur_y   = c.y;
					table_rows[c.index].pattern = c.pattern;
				end
				CMD_HIDE_ONE: table_rows[c.index].cur_y = HIDDEN_Y;
				CMD_ERASE: begin
					// ascending: erase oldest, then age middle into oldest
					for (int i = 0; i < SPRITE_COUNT_DEF; i++) begin
						r = table_rows[i];
						if (r.old_y < limits.range_y && r.old_x < limits.range_x_small)
							add_action(ACT_ERASE, r.old_x, r.old_y, '0);
						if (r.mid_y < limits.range_y || r.old_y < limits.range_y) begin
							table_rows[i].old_x = r.mid_x;
							table_rows[i].old_y = r.mid_y;
						end
					end
					close_pass();
				end
				CMD_DRAW: begin
					// descending: draw current, then age current into middle
					for (int i = SPRITE_COUNT_DEF - 1; i >= 0; i--) begin
						r = table_rows[i];
						if (r.cur_y < limits.range_y) begin
							if (r.pattern < limits.large_pattern_start) begin
								if (r.cur_x < limits.range_x_small)
									add_action(ACT_DRAW_SMALL, r.cur_x, r.cur_y, r.pattern);
							end else if (r.cur_x < limits.range_x_large) begin
								add_action(ACT_DRAW_LARGE, r.cur_x, r.cur_y, r.pattern);
							end
						end
						if (r.cur_y < limits.range_y || r.mid_y < limits.range_y) begin
							table_rows[i].mid_x = r.cur_x;
							table_rows[i].mid_y = r.cur_y;
						end
					end
					close_pass();
				end
				default: ;
			endcase
		endfunction

		task report_mismatch(input string msg);
			mismatches++;
			if (mismatches <= MAX_PRINTED)
				$display("[%0t] %s", $time, msg);
		endtask

		task check_action(input sprite_action_t got);
			sprite_action_t want;
			if (expected_actions.size() == 0) begin
				report_mismatch($sformatf("unexpected action %0d at x=%0d y=%0d",
					got.act.action, got.act.x, got.act.y));
				return;
			end
			want = expected_actions.pop_front();
			if (got.act.action !== want.act.action)
				report_mismatch($sformatf("action: got %0d, want %0d",
					got.act.action, want.act.action));
			if (got.act.x !== want.act.x)
				report_mismatch($sformatf("out_x: got %0d, want %0d", got.act.x, want.act.x));
			if (got.act.y !== want.act.y)
				report_mismatch($sformatf("out_y: got %0d, want %0d", got.act.y, want.act.y));
			if (got.act.pattern !== want.act.pattern)
				report_mismatch($sformatf("out_pattern: got %0d, want %0d",
					got.act.pattern, want.act.pattern));
			if (got.last !== want.last)
				report_mismatch($sformatf("last: got %0d, want %0d", got.last, want.last));
		endtask
	endclass

	logic                   clk;
	logic                   arst_n;
	logic [S_DATA_W-1:0]    s_tdata;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [M_DATA_W-1:0]    m_tdata;
	logic                   m_tlast;
	logic                   m_tvalid;
	logic                   m_tready;
	logic                   cfg_we;
	logic [REG_IDX_W-1:0]   cfg_index;
	logic [CFG_W-1:0]       cfg_data;

	sprite_action_scoreboard actions_sb = new();
	int sink_stall_odds;
	int source_gap_odds;

	sprite_position_history_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Hard stop well beyond the slowest legal run
	initial begin
		#8_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Check every accepted action
	always @(posedge clk) begin
		sprite_action_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.act.action  = m_tdata[1:0];
			got.act.x       = m_tdata[9:2];
			got.act.y       = m_tdata[17:10];
			got.act.pattern = m_tdata[25:18];
			got.last        = m_tlast;
			actions_sb.check_action(got);
		end
	end

	// Stall the action output in random bursts
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (sink_stall_odds != 0 && $urandom_range(1, sink_stall_odds) == 1) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(negedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	function automatic sprite_cmd_t make_command(input logic [CMD_W-1:0] command,
		input int index, input int x, input int y, input int pattern);
		sprite_cmd_t c;
		c.command = command;
		c.index   = IDX_W'(index);
		c.x       = COORD_W'(x);
		c.y       = COORD_W'(y);
		c.pattern = PAT_W'(pattern);
		return c;
	endfunction

	// Table updates and noise between passes; y mostly visible
	function automatic sprite_cmd_t random_update();
		sprite_cmd_t c;
		int unsigned pick;
		c.index   = IDX_W'($urandom_range(0, SPRITE_COUNT_DEF - 1));
		c.x       = COORD_W'($urandom);
		c.pattern = PAT_W'($urandom);
		if ($urandom_range(0, 3) != 0 && actions_sb.limits.range_y != 0)
			c.y = COORD_W'($urandom_range(0, actions_sb.limits.range_y - 1));
		else
			c.y = COORD_W'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 70)
			c.command = CMD_SHOW;
		else if (pick < 88)
			c.command = CMD_HIDE_ONE;
		else if (pick < 93)
			c.command = CMD_HIDE_ALL;
		else
			c.command = CMD_SPARE_5 + 3'($urandom_range(0, 2));
		return c;
	endfunction

	// Limits per phase; range_y above HIDDEN_Y is safe since every entry
	// gets a pattern in the directed part
	function automatic cfg_t phase_limits(input int phase);
		cfg_t c;
		case (phase)
			0: c = CFG_RESET;
			1: c = '{8'd0, 8'd0, 8'd0, 8'd0};
			2: c = '{8'd255, 8'd255, 8'd255, 8'd0};
			3: c = '{8'd1, 8'd1, 8'd1, 8'd255};
			default: begin
				c.range_x_small       = CFG_W'($urandom);
				c.range_x_large       = CFG_W'($urandom);
				c.large_pattern_start = CFG_W'($urandom);
				case ($urandom_range(0, 3))
					0: c.range_y = HIDDEN_Y;
					1: c.range_y = 8'd255;
					default: c.range_y = CFG_W'($urandom);
				endcase
			end
		endcase
		return c;
	endfunction

	// Offer one item, with an optional gap first; returns at a falling edge
	task automatic offer_command(input sprite_cmd_t c);
		if (source_gap_odds != 0 && $urandom_range(1, source_gap_odds) == 1) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		s_tdata  <= {1'b0, c};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		actions_sb.note_command(c);
		@(negedge clk);
	endtask

	// Hold the sender until every action is out and the block is idle
	task automatic drain_block();
		s_tvalid <= 1'b0;
		while (actions_sb.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Write all four registers on consecutive cycles
	task automatic load_limits(input cfg_t c);
		logic [REG_IDX_W-1:0] regs [4];
		logic [CFG_W-1:0]     vals [4];
		regs = '{REG_RANGE_X_SMALL, REG_RANGE_X_LARGE, REG_RANGE_Y, REG_LARGE_START};
		vals = '{c.range_x_small, c.range_x_large, c.range_y, c.large_pattern_start};
		cfg_we <= 1'b1;
		for (int k = 0; k < 4; k++) begin
			cfg_index <= regs[k];
			cfg_data  <= vals[k];
			@(negedge clk);
			actions_sb.set_register(regs[k], vals[k]);
		end
		cfg_we <= 1'b0;
	endtask

	initial begin
		sprite_cmd_t c;
		int          sent;
		arst_n    = 1'b0;
		s_tdata   = '0;
		s_tvalid  = 1'b0;
		m_tready  = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		sink_stall_odds = 4;
		source_gap_odds = 4;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: show every entry with field extremes on the first few
		for (int i = 0; i < SPRITE_COUNT_DEF; i++) begin
			c = make_command(CMD_SHOW, i, $urandom, $urandom_range(0, 223), $urandom);
			case (i)
				0: begin c.x = 8'd0;   c.y = 8'd0;   c.pattern = 8'd0;   end
				1: begin c.x = 8'd255; c.y = 8'd223; c.pattern = 8'd255; end
				2: begin c.x = 8'd254; c.y = 8'd224; c.pattern = 8'd127; end
				3: begin c.x = 8'd1;   c.y = 8'd255; c.pattern = 8'd128; end
				default: ;
			endcase
			offer_command(c);
		end
		offer_command(make_command(CMD_DRAW, 0, 0, 0, 0));
		offer_command(make_command(CMD_ERASE, 0, 0, 0, 0));
		offer_command(make_command(CMD_DRAW, 0, 0, 0, 0));
		offer_command(make_command(CMD_ERASE, 0, 0, 0, 0));
		offer_command(make_command(CMD_HIDE_ONE, 15, 0, 0, 0));
		offer_command(make_command(CMD_DRAW, 0, 0, 0, 0));
		offer_command(make_command(CMD_HIDE_ALL, 0, 0, 0, 0));
		// erase pass over a fully hidden table emits nothing
		offer_command(make_command(CMD_ERASE, 0, 0, 0, 0));
		offer_command(make_command(CMD_SPARE_7, 15, 255, 255, 255));

		// Random frames: updates, then erase and draw, sometimes one skipped
		for (int phase = 0; phase < PHASES; phase++) begin
			drain_block();
			load_limits(phase_limits(phase));
			if (phase == PHASES - 1) begin
				sink_stall_odds = 0;
				source_gap_odds = 0;
			end else begin
				sink_stall_odds = $urandom_range(0, 3) * 4;
				source_gap_odds = $urandom_range(0, 3) * 4;
			end
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				repeat ($urandom_range(0, 5)) begin
					offer_command(random_update());
					sent++;
				end
				if ($urandom_range(0, 9) != 0) begin
					offer_command(make_command(CMD_ERASE, $urandom, $urandom, $urandom, $urandom));
					sent++;
				end
				if ($urandom_range(0, 9) != 0) begin
					offer_command(make_command(CMD_DRAW, $urandom, $urandom, $urandom, $urandom));
					sent++;
				end
			end
		end

		drain_block();
		if (actions_sb.mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

/* files.f */
sv/sphist_pkg.sv
sv/sphist_ram.sv
sv/sphist_unit.sv
sv/sprite_position_history_table.sv
sv/sphist_checker.sv
tb/sprite_position_history_table_tb.sv
